// ===== hdl/fcsfp_pkg.sv =====
// Shared constants, types and lookup functions for the fixed-column frame parser.
// Holds the field column map, character codes and fixed-point scaling constants.
// No dependencies; used by fcsfp_field_parser and fixed_column_sensor_frame_parser.
package fcsfp_pkg;

  localparam int FRAME_LENGTH    = 46;
  localparam int FRACTION_DIGITS = 2;
  localparam int NUM_FIELDS      = 10;

  localparam int COL_W      = 6;
  localparam int FIELD_W    = 4;
  localparam int CHAR_W     = 7;
  localparam int RX_W       = 8;
  localparam int MAG_W      = 30;
  localparam int ACC_W      = 35;
  localparam int VALUE_W    = 31;
  localparam int FRAC_CNT_W = 3;
  localparam int FRAC_DEPTH = 8;

  localparam logic [COL_W-1:0]   FRAME_END_COL = COL_W'(FRAME_LENGTH);
  localparam logic [FIELD_W-1:0] LAST_FIELD    = FIELD_W'(NUM_FIELDS - 1);

  // Character codes after bit 7 has been dropped.
  localparam logic [CHAR_W-1:0] CODE_STX = 7'h02;
  localparam logic [CHAR_W-1:0] CODE_ETX = 7'h03;
  localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH = 7'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;

  function automatic longint pow10(int n);
    longint p;
    p = 1;
    for (int k = 0; k < n; k++) begin
      p = p * 10;
    end
    return p;
  endfunction

  function automatic logic [MAG_W-1:0] frac_weight(int k);
    return (k < FRACTION_DIGITS) ? MAG_W'(pow10(FRACTION_DIGITS - 1 - k)) : '0;
  endfunction

  localparam longint            SCALE        = pow10(FRACTION_DIGITS);
  localparam logic [MAG_W-1:0]  SCALE_MAG    = MAG_W'(SCALE);
  localparam logic [ACC_W-1:0]  VALUE_LIMIT  = ACC_W'(999999999);
  localparam logic [VALUE_W-1:0] LIMIT_VALUE = VALUE_W'(999999999);
  localparam logic [VALUE_W-1:0] MISSING_VALUE = VALUE_W'(-SCALE);
  localparam logic [FRAC_CNT_W-1:0] FRAC_CNT_MAX = FRAC_CNT_W'(FRACTION_DIGITS);

  // Weight of each fraction digit position; positions past the kept digits weigh zero.
  localparam logic [MAG_W-1:0] FRAC_WEIGHT [FRAC_DEPTH] = '{
    frac_weight(0), frac_weight(1), frac_weight(2), frac_weight(3),
    frac_weight(4), frac_weight(5), frac_weight(6), frac_weight(7)
  };

  // Field column map: first and last column of each field.
  localparam logic [COL_W-1:0] FIELD_FIRST [NUM_FIELDS] = '{
    6'd0, 6'd1, 6'd2, 6'd8, 6'd18, 6'd21, 6'd24, 6'd27, 6'd34, 6'd41
  };
  localparam logic [COL_W-1:0] FIELD_LAST_COL [NUM_FIELDS] = '{
    6'd0, 6'd1, 6'd7, 6'd13, 6'd20, 6'd23, 6'd26, 6'd33, 6'd40, 6'd45
  };

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_STOP
  } parse_phase_t;

  typedef struct packed {
    logic               in_field;
    logic               first;
    logic               last;
    logic [FIELD_W-1:0] field;
  } col_info_t;

  typedef struct packed {
    logic             slash;
    logic             neg;
    logic             over;
    logic [MAG_W-1:0] mag;
  } field_raw_t;

  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] field;
    field_raw_t         raw;
  } field_done_t;

  function automatic col_info_t col_lookup(logic [COL_W-1:0] col);
    col_info_t info;
    info = '0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (col >= FIELD_FIRST[i] && col <= FIELD_LAST_COL[i]) begin
        info.in_field = 1'b1;
        info.first    = (col == FIELD_FIRST[i]);
        info.last     = (col == FIELD_LAST_COL[i]);
        info.field    = FIELD_W'(i);
      end
    end
    return info;
  endfunction

endpackage

// ===== hdl/fixed_column_sensor_frame_parser.sv =====
// Top level of the fixed-column sensor frame parser.
// Counts columns, keeps the per-field results and drains the ten-word result burst.
// Depends on fcsfp_pkg and fcsfp_field_parser.

// The block takes one received word per clock cycle while in_ready is high, with bit 7
// ignored. Code 0x02 restarts the column count, and code 0x03 ends a frame only when it
// arrives at column 46; every other word is a character of the frame and is parsed as it
// arrives, so no frame buffer is kept. Each field is parsed by one shared parser as its
// columns stream past, and its raw result lands in a ten-entry working bank on the field's
// last column. The end code copies that bank into a separate output bank, and the ten result
// words then leave one per cycle while out_ready is high, field 0 first, with out_last set
// on field 9. in_ready stays high at all times except when the column count sits at 46 and
// the previous burst has not yet fully left the output bank; since a frame takes at least
// 47 words, a burst that drains at full rate never stalls the input. Values are in
// hundredths with further fraction digits dropped, saturate at plus or minus 999999999,
// and a field holding a slash reports missing with value -100.
module fixed_column_sensor_frame_parser
  import fcsfp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [RX_W-1:0]           in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [FIELD_W-1:0]        out_field_index,
  output logic signed [VALUE_W-1:0] out_value_hundredths,
  output logic                      out_missing,
  output logic                      out_last
);

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [CHAR_W-1:0]  rx_char;
  logic               in_accept;
  logic               is_stx, is_end, is_data;

  logic               a_ch_valid_r;
  logic [CHAR_W-1:0]  a_ch_r;
  col_info_t          a_info_r;
  logic               a_end_r;

  field_done_t        done;
  field_raw_t         work_bank_r [NUM_FIELDS];
  field_raw_t         out_bank_r  [NUM_FIELDS];

  logic               busy_r;
  logic [FIELD_W-1:0] ptr_r;
  logic               emit;
  field_raw_t         cur;
  logic [VALUE_W-1:0] mag_sel, value_sel;

  logic               out_valid_r;
  logic [FIELD_W-1:0] out_field_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_missing_r;
  logic               out_last_r;

  // Only a frame end needs the output bank, so hold off only when one could arrive.
  assign in_ready  = !((col_r == FRAME_END_COL) && busy_r);
  assign in_accept = in_valid && in_ready;
  assign rx_char   = in_rx_byte[CHAR_W-1:0];
  assign is_stx    = (rx_char == CODE_STX);
  assign is_end    = !is_stx && (rx_char == CODE_ETX) && (col_r == FRAME_END_COL);
  assign is_data   = !is_stx && !is_end;

  // Column count saturates one past the frame so that late words are neither stored
  // nor able to end a frame; only a restart code recovers.
  always_comb begin
    col_nxt = col_r;
    if (is_stx || is_end) begin
      col_nxt = '0;
    end else if (col_r <= FRAME_END_COL) begin
      col_nxt = col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      a_ch_valid_r <= 1'b0;
      a_end_r      <= 1'b0;
    end else begin
      a_ch_valid_r <= in_accept && is_data && (col_r < FRAME_END_COL);
      a_end_r      <= in_accept && is_end;
      if (in_accept) begin
        col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_ch_r   <= rx_char;
      a_info_r <= col_lookup(col_r);
    end
  end

  fcsfp_field_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .ch_valid (a_ch_valid_r),
    .ch       (a_ch_r),
    .info     (a_info_r),
    .done     (done)
  );

  always_ff @(posedge clk) begin
    if (done.valid) begin
      work_bank_r[done.field] <= done.raw;
    end
  end

  // The last field is written to the working bank no later than the end code is registered,
  // so the copy always sees a complete frame.
  always_ff @(posedge clk) begin
    if (a_end_r) begin
      out_bank_r <= work_bank_r;
    end
  end

  assign emit = busy_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ptr_r  <= '0;
    end else if (a_end_r) begin
      busy_r <= 1'b1;
      ptr_r  <= '0;
    end else if (emit) begin
      ptr_r <= ptr_r + FIELD_W'(1);
      if (ptr_r == LAST_FIELD) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Turn the raw magnitude, sign and flags of the selected field into the result value.
  always_comb begin
    cur       = out_bank_r[ptr_r];
    mag_sel   = cur.over ? LIMIT_VALUE : {1'b0, cur.mag};
    value_sel = cur.neg ? (~mag_sel + VALUE_W'(1)) : mag_sel;
    if (cur.slash) begin
      value_sel = MISSING_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_field_r   <= ptr_r;
      out_value_r   <= value_sel;
      out_missing_r <= cur.slash;
      out_last_r    <= (ptr_r == LAST_FIELD);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_field_index      = out_field_r;
  assign out_value_hundredths = $signed(out_value_r);
  assign out_missing          = out_missing_r;
  assign out_last             = out_last_r;

endmodule

// ===== hdl/fcsfp_field_parser.sv =====
// Column-by-column decimal parser shared by all fields of the frame. Consumes one stored
// character per cycle while ch_valid is high and reports the raw result on a field's last
// column. Depends on fcsfp_pkg.
module fcsfp_field_parser
  import fcsfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ch_valid,
  input  logic [CHAR_W-1:0] ch,
  input  col_info_t         info,
  output field_done_t       done
);

  parse_phase_t            phase_r, phase_nxt, phase_base;
  logic                    neg_r, neg_nxt, neg_base;
  logic                    over_r, over_nxt, over_base;
  logic                    slash_r, slash_nxt, slash_base;
  logic [MAG_W-1:0]        mag_r, mag_nxt, mag_base;
  logic [FRAC_CNT_W-1:0]   fcnt_r, fcnt_nxt, fcnt_base;

  logic                    is_ws, is_digit, is_sign, is_point;
  logic [3:0]              digit;
  logic [ACC_W-1:0]        acc;
  logic                    take;

  assign take = ch_valid && info.in_field;

  // The first column of a field starts from a fresh state.
  assign phase_base = info.first ? PH_LEAD : phase_r;
  assign neg_base   = info.first ? 1'b0 : neg_r;
  assign over_base  = info.first ? 1'b0 : over_r;
  assign slash_base = info.first ? 1'b0 : slash_r;
  assign mag_base   = info.first ? '0 : mag_r;
  assign fcnt_base  = info.first ? '0 : fcnt_r;

  assign is_ws    = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign is_point = (ch == CH_POINT);
  assign digit    = ch[3:0];

  always_comb begin
    phase_nxt = PH_STOP;
    unique case (phase_base)
      PH_LEAD: begin
        if (is_ws) begin
          phase_nxt = PH_LEAD;
        end else if (is_sign || is_digit) begin
          phase_nxt = PH_INT;
        end else if (is_point) begin
          phase_nxt = PH_FRAC;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          phase_nxt = PH_INT;
        end else if (is_point) begin
          phase_nxt = PH_FRAC;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          phase_nxt = PH_FRAC;
        end
      end
      PH_STOP: begin
        phase_nxt = PH_STOP;
      end
      default: begin
        phase_nxt = PH_STOP;
      end
    endcase
  end

  always_comb begin
    neg_nxt   = neg_base;
    mag_nxt   = mag_base;
    fcnt_nxt  = fcnt_base;
    over_nxt  = over_base;
    slash_nxt = slash_base || (ch == CH_SLASH);
    acc       = ACC_W'(mag_base);
    if (phase_base == PH_LEAD && ch == CH_MINUS) begin
      neg_nxt = 1'b1;
    end
    if (is_digit && (phase_base == PH_LEAD || phase_base == PH_INT)) begin
      acc = ACC_W'(mag_base) * ACC_W'(10) + ACC_W'(digit) * ACC_W'(SCALE_MAG);
    end else if (is_digit && phase_base == PH_FRAC) begin
      acc = ACC_W'(mag_base) + ACC_W'(digit) * ACC_W'(FRAC_WEIGHT[fcnt_base]);
      if (fcnt_base < FRAC_CNT_MAX) begin
        fcnt_nxt = fcnt_base + FRAC_CNT_W'(1);
      end
    end
    // Once the magnitude passes the limit it can only grow, so the flag is sticky.
    mag_nxt  = acc[MAG_W-1:0];
    over_nxt = over_base || (acc > VALUE_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
    end else if (take) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      neg_r   <= neg_nxt;
      over_r  <= over_nxt;
      slash_r <= slash_nxt;
      mag_r   <= mag_nxt;
      fcnt_r  <= fcnt_nxt;
    end
  end

  always_comb begin
    done.valid     = take && info.last;
    done.field     = info.field;
    done.raw.slash = slash_nxt;
    done.raw.neg   = neg_nxt;
    done.raw.over  = over_nxt;
    done.raw.mag   = mag_nxt;
  end

endmodule
